// ===== hdl/sfr_pkg.sv =====
// Shared types and constants of the spike fan-out router.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

   // Field widths fixed by the item formats
   localparam int LABEL_W    = 16;
   localparam int TIME_W     = 32;
   localparam int DELAY_W    = 24;
   localparam int SLOT_IN_W  = 6;
   localparam int INDEX_IN_W = 3;
   localparam int COUNT_IN_W = 4;
   localparam int OP_W       = 2;

   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 48;

   // Operation codes carried in req_tuser
   localparam logic [OP_W-1:0] OP_SPIKE   = 2'd0;
   localparam logic [OP_W-1:0] OP_SLOT_WR = 2'd1;
   localparam logic [OP_W-1:0] OP_TGT_WR  = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // Input item payload, last field in the lowest bits
   typedef struct packed {
      logic [2:0]            spare;
      logic [DELAY_W-1:0]    delay;
      logic [LABEL_W-1:0]    dst_label;
      logic [COUNT_IN_W-1:0] fanout_count;
      logic [INDEX_IN_W-1:0] target_index;
      logic [SLOT_IN_W-1:0]  slot;
      logic [TIME_W-1:0]     spike_time;
      logic [LABEL_W-1:0]    src_label;
   } req_data_type;

   // Result item payload, last field in the lowest bits
   typedef struct packed {
      logic [TIME_W-1:0]  out_time;
      logic [LABEL_W-1:0] out_label;
   } rsp_data_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_en;
      logic wr_slot;
      logic wr_tgt;
      logic scan_start;
      logic scan_en;
      logic emit_en;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_done;
      logic hit;
      logic miss_done;
      logic emit_done;
   } status_type;

endpackage

`default_nettype wire

// ===== hdl/sfr_ctrl.sv =====
// Controller state machine of the spike fan-out router.
`timescale 1ns / 1ps
`default_nettype none

module sfr_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [sfr_pkg::OP_W-1:0]     req_op,
   input  sfr_pkg::status_type          status,
   output logic                         req_ready,
   output sfr_pkg::cmd_type             cmd
);
   import sfr_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = req_valid && req_ready;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && (req_op == OP_SPIKE)) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.hit) state_in = ST_EMIT;
            else if (status.miss_done) state_in = ST_IDLE;
         end
         ST_EMIT: begin
            if (status.emit_done) state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      cmd.clear_en   = (state_ff == ST_CLEAR);
      cmd.wr_slot    = (state_ff == ST_IDLE) && req_valid && (req_op == OP_SLOT_WR);
      cmd.wr_tgt     = (state_ff == ST_IDLE) && req_valid && (req_op == OP_TGT_WR);
      cmd.scan_start = (state_ff == ST_IDLE) && req_valid && (req_op == OP_SPIKE);
      cmd.scan_en    = (state_ff == ST_SCAN);
      cmd.emit_en    = (state_ff == ST_EMIT);
   end

endmodule

`default_nettype wire

// ===== hdl/sfr_datapath.sv =====
// Datapath of the spike fan-out router: slot and target memories, scan, emit pipeline.
`timescale 1ns / 1ps
`default_nettype none

module sfr_datapath #(
   parameter int SLOTS      = 64,
   parameter int MAX_FANOUT = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sfr_pkg::cmd_type      cmd,
   input  sfr_pkg::req_data_type req_data,
   output sfr_pkg::status_type   status,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sfr_pkg::rsp_data_type rsp_data,
   output logic                  rsp_last
);
   import sfr_pkg::*;

   localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PW     = $clog2(SLOTS + 1);
   localparam int TDEPTH = SLOTS * MAX_FANOUT;
   localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
   localparam int CW     = $clog2(MAX_FANOUT + 1);
   localparam int SE_W   = LABEL_W + CW;
   localparam int TE_W   = LABEL_W + DELAY_W;

   // Memories: slot entry is {key, count}, target entry is {label, delay}
   logic [SE_W-1:0] slot_mem [SLOTS];
   logic [TE_W-1:0] tgt_mem  [TDEPTH];

   logic [SE_W-1:0] slot_rd_ff;
   logic [TE_W-1:0] tgt_rd_ff;

   // Write-side decode
   logic            slot_in_range;
   logic            index_in_range;
   logic [CW-1:0]   cnt_clamped;
   logic            slot_we;
   logic [SW-1:0]   slot_waddr;
   logic [SE_W-1:0] slot_wdata;
   logic            tgt_we;
   logic [TAW-1:0]  tgt_waddr;

   // Clearing pass
   logic [SW-1:0] clr_ptr_ff, clr_ptr_in;

   // Scan state
   logic [LABEL_W-1:0] key_ff, key_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [PW-1:0]      scan_ptr_ff, scan_ptr_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [SW-1:0]      cmp_slot_ff, cmp_slot_in;
   logic               slot_rd_en;
   logic [LABEL_W-1:0] rd_key;
   logic [CW-1:0]      rd_cnt;
   logic               match;

   // Emit state
   logic [TAW-1:0] base_ff, base_in;
   logic [CW-1:0]  n_ff, n_in;
   logic [CW-1:0]  iss_ff, iss_in;
   logic           rd_valid_ff, rd_valid_in;
   logic           rd_last_ff, rd_last_in;
   logic           iss_more;
   logic           tgt_rd_en;
   logic [TAW-1:0] tgt_raddr;
   logic           out_load;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LABEL_W-1:0]  out_label_ff;
   logic [TIME_W-1:0]   out_time_ff;
   logic                out_last_ff;
   logic [TIME_W:0]     time_sum;

   // Write decode; oversized counts store as the list length
   always_comb begin
      slot_in_range  = int'(req_data.slot) < SLOTS;
      index_in_range = int'(req_data.target_index) < MAX_FANOUT;
      cnt_clamped    = (int'(req_data.fanout_count) > MAX_FANOUT) ? CW'(MAX_FANOUT)
                                                                  : CW'(req_data.fanout_count);
      slot_we    = cmd.clear_en || (cmd.wr_slot && slot_in_range);
      slot_waddr = cmd.clear_en ? clr_ptr_ff : SW'(req_data.slot);
      slot_wdata = cmd.clear_en ? '0 : {req_data.src_label, cnt_clamped};
      tgt_we     = cmd.wr_tgt && slot_in_range && index_in_range;
      tgt_waddr  = TAW'(int'(req_data.slot) * MAX_FANOUT + int'(req_data.target_index));
   end

   // Slot memory
   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
   end

   always_ff @(posedge clock) begin
      if (slot_rd_en) slot_rd_ff <= slot_mem[scan_ptr_ff[SW-1:0]];
   end

   // Target memory
   always_ff @(posedge clock) begin
      if (tgt_we) tgt_mem[tgt_waddr] <= {req_data.dst_label, req_data.delay};
   end

   always_ff @(posedge clock) begin
      if (tgt_rd_en) tgt_rd_ff <= tgt_mem[tgt_raddr];
   end

   // Scan compare, one slot per cycle, lowest match wins
   always_comb begin
      rd_key     = slot_rd_ff[SE_W-1:CW];
      rd_cnt     = slot_rd_ff[CW-1:0];
      slot_rd_en = cmd.scan_en && (scan_ptr_ff < PW'(SLOTS));
      match      = cmd.scan_en && cmp_valid_ff && (rd_cnt != '0) && (rd_key == key_ff);
   end

   // Emit pipeline: target read stage, then output register
   always_comb begin
      out_load  = rd_valid_ff && (!rsp_valid_ff || rsp_ready);
      iss_more  = cmd.emit_en && (iss_ff < n_ff);
      tgt_rd_en = iss_more && (!rd_valid_ff || out_load);
      tgt_raddr = base_ff + TAW'(iss_ff);
      time_sum  = {1'b0, time_ff} + (TIME_W + 1)'(tgt_rd_ff[DELAY_W-1:0]);
   end

   // Next values of the control registers
   always_comb begin
      clr_ptr_in   = clr_ptr_ff;
      key_in       = key_ff;
      time_in      = time_ff;
      scan_ptr_in  = scan_ptr_ff;
      cmp_valid_in = 1'b0;
      cmp_slot_in  = cmp_slot_ff;
      base_in      = base_ff;
      n_in         = n_ff;
      iss_in       = iss_ff;
      rd_valid_in  = rd_valid_ff;
      rd_last_in   = rd_last_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.clear_en) clr_ptr_in = clr_ptr_ff + SW'(1);

      if (cmd.scan_start) begin
         key_in      = req_data.src_label;
         time_in     = req_data.spike_time;
         scan_ptr_in = '0;
      end else if (cmd.scan_en) begin
         cmp_valid_in = slot_rd_en;
         cmp_slot_in  = scan_ptr_ff[SW-1:0];
         if (slot_rd_en) scan_ptr_in = scan_ptr_ff + PW'(1);
      end

      // Latch the winning slot's list
      if (match) begin
         base_in = TAW'(int'(cmp_slot_ff) * MAX_FANOUT);
         n_in    = rd_cnt;
         iss_in  = '0;
      end

      if (tgt_rd_en) begin
         iss_in      = iss_ff + CW'(1);
         rd_last_in  = ((iss_ff + CW'(1)) == n_ff);
         rd_valid_in = 1'b1;
      end else if (out_load) begin
         rd_valid_in = 1'b0;
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff   <= '0;
         scan_ptr_ff  <= '0;
         cmp_valid_ff <= 1'b0;
         iss_ff       <= '0;
         n_ff         <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ptr_ff   <= clr_ptr_in;
         scan_ptr_ff  <= scan_ptr_in;
         cmp_valid_ff <= cmp_valid_in;
         iss_ff       <= iss_in;
         n_ff         <= n_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      time_ff     <= time_in;
      cmp_slot_ff <= cmp_slot_in;
      base_ff     <= base_in;
      rd_last_ff  <= rd_last_in;
      if (out_load) begin
         out_label_ff <= tgt_rd_ff[TE_W-1:DELAY_W];
         out_time_ff  <= time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
         out_last_ff  <= rd_last_ff;
      end
   end

   // Status and result outputs
   always_comb begin
      status.clear_done = cmd.clear_en && (clr_ptr_ff == SW'(SLOTS - 1));
      status.hit        = match;
      status.miss_done  = cmd.scan_en && cmp_valid_ff && !match
                          && (cmp_slot_ff == SW'(SLOTS - 1));
      status.emit_done  = cmd.emit_en && (iss_ff == n_ff) && !rd_valid_ff;
      rsp_valid          = rsp_valid_ff;
      rsp_data.out_label = out_label_ff;
      rsp_data.out_time  = out_time_ff;
      rsp_last           = out_last_ff;
   end

endmodule

`default_nettype wire

// ===== hdl/spike_fanout_router_top.sv =====
// Top level of the spike fan-out router.
//
// Routes timed spikes through a multicast table. Write items load slot keys with
// fan-out counts and target (label, delay) entries; each is stored as it is
// accepted. A spike item scans the slot memory one slot per cycle through its
// single read port and stops at the lowest-numbered enabled slot with a matching
// key, then reads that slot's targets from the target memory one per cycle while
// the output is not stalled and sends one result per target, time plus delay
// saturated at the time maximum, tlast on the final one. No new item is taken
// while a spike is scanned or its results are issued. The last result may still
// wait in the output register while the next item is accepted. After reset a
// clearing pass zeroes all slot counts, and no item is accepted until it ends.
// Target entries must be written before a spike uses them.
`timescale 1ns / 1ps
`default_nettype none

module spike_fanout_router_top #(
   parameter int SLOTS      = 64,
   parameter int MAX_FANOUT = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // src_label[15:0], spike_time[47:16], slot[53:48], target_index[56:54],
   // fanout_count[60:57], dst_label[76:61], delay[100:77], zero[103:101]
   input  logic [sfr_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // operation[1:0]
   input  logic [sfr_pkg::OP_W-1:0]          req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_label[15:0], out_time[47:16]
   output logic [sfr_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);
   import sfr_pkg::*;

   cmd_type      cmd;
   status_type   status;
   req_data_type req_data;
   rsp_data_type rsp_data;

   assign req_data  = req_tdata;
   assign rsp_tdata = rsp_data;

   // Controller
   sfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (req_tuser),
      .status    (status),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   // Datapath
   sfr_datapath #(
      .SLOTS      (SLOTS),
      .MAX_FANOUT (MAX_FANOUT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .status    (status),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data),
      .rsp_last  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== hdl/sfr_checker.sv =====
// Port-level assertions for the spike fan-out router, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module sfr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [sfr_pkg::OP_W-1:0]        req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sfr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import sfr_pkg::*;

   // Reset empties the output and starts the clearing pass
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !req_tready))
      else $error("output valid or input ready right after reset");

   // An accepted spike occupies the block for its scan
   a_spike_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == OP_SPIKE)) |=> !req_tready)
      else $error("input ready in the cycle after a spike item");

   // Results only start while a spike is being served
   a_result_in_service: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result raised while the block was idle");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed or dropped");

endmodule

bind spike_fanout_router_top sfr_checker u_sfr_checker (.*);

`default_nettype wire
